@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

@@ rtl/w8u16dec_pkg.sv @@
// ---------------------------------------------------------------------------
// w8u16dec_pkg
// Constants and decode functions for the byte to UTF-16 code unit decoder.
// ---------------------------------------------------------------------------
package w8u16dec_pkg;

  localparam logic [15:0] UnitReplacement = 16'hFFFD;
  localparam logic [15:0] SurrHigh        = 16'hD800;
  localparam logic [15:0] SurrLow         = 16'hDC00;
  localparam logic [31:0] SuppOffset      = 32'h0001_0000;

  typedef logic [15:0] unit_t;
  typedef logic [1:0]  unit_cnt_t;

  // 1 for ASCII, 2..4 for a lead byte, 0 for a stray byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic unit_t dec2(input logic [7:0] s0, input logic [7:0] s1);
    return {5'd0, s0[4:0], s1[5:0]};
  endfunction

  function automatic unit_t dec3(input logic [7:0] s0, input logic [7:0] s1,
                                 input logic [7:0] s2);
    return {s0[3:0], s1[5:0], s2[5:0]};
  endfunction

  // high half in the upper 16 bits, low half in the lower 16 bits
  function automatic logic [31:0] dec4(input logic [7:0] s0, input logic [7:0] s1,
                                       input logic [7:0] s2, input logic [7:0] s3);
    logic [31:0] cp;
    logic [31:0] v;
    cp = {11'd0, s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
    v  = cp - SuppOffset;
    return {SurrHigh | v[25:10], SurrLow | {6'd0, v[9:0]}};
  endfunction

  // a lone byte at the end of a string
  function automatic unit_t tail1(input logic [7:0] b);
    return (b[7] == 1'b0) ? {8'd0, b} : UnitReplacement;
  endfunction

endpackage

@@ rtl/wtf8_to_utf16_decoder.sv @@
// ---------------------------------------------------------------------------
// wtf8_to_utf16_decoder
// Byte stream to UTF-16 code unit stream, surrogates passed through.
// ---------------------------------------------------------------------------
// One string byte enters per word on the slave side, with tlast on the final
// byte of the string. Each byte is decoded in the cycle it is accepted and its
// code units (none, one, two or three) go into an output buffer that drains
// one unit per cycle while m_tready is high; the first unit appears in the next
// cycle. A byte with no unit does not hold the input and one with one unit
// frees it as that unit is taken, so plain text flows at one byte per cycle
// while m_tready is high. A byte that yields more holds the input until the
// single output buffer has drained: a 4-byte sequence yields 2 units, an
// open one at string end up to 3. On the master side tuser marks the last
// unit caused by one input byte and tlast marks the final unit of the string.
`include "assert_macros.svh"

module wtf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // string_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser,   // [0] run_last
  output logic        m_tlast    // string_done
);

  logic [7:0]  pend [3];
  logic [1:0]  cnt;
  logic [2:0]  seqlen;

  w8u16dec_pkg::unit_t     unit [3];
  w8u16dec_pkg::unit_cnt_t n;
  logic [1:0]              idx;
  logic                    end_flag;
  logic                    busy;

  w8u16dec_pkg::unit_t     u0_next, u1_next, u2_next;
  w8u16dec_pkg::unit_cnt_t n_next;
  logic [1:0]              cnt_next;
  logic [2:0]              seqlen_next;
  logic                    pend_we;
  logic [1:0]              pend_wi;

  logic [2:0]  len_b;
  logic [2:0]  len_p1;
  logic        open_seq;
  logic [1:0]  held;
  logic [2:0]  total;
  logic [31:0] pair;
  logic        last_u;
  logic        load;
  logic        take;

  assign last_u   = busy && (idx == (n - 2'd1));
  assign s_tready = !busy || (last_u && m_tready);
  assign load     = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;

  assign m_tvalid = busy;
  assign m_tdata  = unit[idx];
  assign m_tuser  = last_u;
  assign m_tlast  = last_u && end_flag;

  always_comb begin
    len_b    = w8u16dec_pkg::lead_len(s_tdata);
    len_p1   = w8u16dec_pkg::lead_len(pend[1]);
    open_seq = (seqlen == 3'd2) || (seqlen == 3'd3) || (seqlen == 3'd4);
    held     = (cnt == 2'd0) ? 2'd1 : cnt;
    total    = {1'b0, held} + 3'd1;
    pair     = w8u16dec_pkg::dec4(pend[0], pend[1], pend[2], s_tdata);

    u0_next     = '0;
    u1_next     = '0;
    u2_next     = '0;
    n_next      = 2'd0;
    cnt_next    = cnt;
    seqlen_next = seqlen;
    pend_we     = 1'b0;
    pend_wi     = 2'd0;

    if (!open_seq) begin
      if (len_b == 3'd1) begin
        u0_next = {8'd0, s_tdata};
        n_next  = 2'd1;
      end else if (len_b == 3'd0 || s_tlast) begin
        u0_next = w8u16dec_pkg::UnitReplacement;
        n_next  = 2'd1;
      end else begin
        pend_we     = 1'b1;
        pend_wi     = 2'd0;
        cnt_next    = 2'd1;
        seqlen_next = len_b;
      end
    end else if (total >= seqlen) begin
      case (seqlen)
        3'd2: begin
          u0_next = w8u16dec_pkg::dec2(pend[0], s_tdata);
          n_next  = 2'd1;
        end
        3'd3: begin
          u0_next = w8u16dec_pkg::dec3(pend[0], pend[1], s_tdata);
          n_next  = 2'd1;
        end
        default: begin
          u0_next = pair[31:16];
          u1_next = pair[15:0];
          n_next  = 2'd2;
        end
      endcase
      cnt_next    = 2'd0;
      seqlen_next = 3'd0;
    end else if (s_tlast) begin
      u0_next = w8u16dec_pkg::UnitReplacement;
      if (held == 2'd1) begin
        u1_next = w8u16dec_pkg::tail1(s_tdata);
        n_next  = 2'd2;
      end else if (len_p1 == 3'd1) begin
        u1_next = {8'd0, pend[1]};
        u2_next = w8u16dec_pkg::tail1(s_tdata);
        n_next  = 2'd3;
      end else if (len_p1 == 3'd2) begin
        u1_next = w8u16dec_pkg::dec2(pend[1], s_tdata);
        n_next  = 2'd2;
      end else begin
        u1_next = w8u16dec_pkg::UnitReplacement;
        u2_next = w8u16dec_pkg::tail1(s_tdata);
        n_next  = 2'd3;
      end
    end else begin
      pend_we  = 1'b1;
      pend_wi  = held;
      cnt_next = held + 2'd1;
    end

    if (s_tlast) begin
      cnt_next    = 2'd0;
      seqlen_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      seqlen <= 3'd0;
      busy   <= 1'b0;
      idx    <= 2'd0;
    end else begin
      if (load) begin
        cnt    <= cnt_next;
        seqlen <= seqlen_next;
        busy   <= (n_next != 2'd0);
        idx    <= 2'd0;
      end else if (take) begin
        if (last_u) begin
          busy <= 1'b0;
        end
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && pend_we) begin
      pend[pend_wi] <= s_tdata;
    end
    if (load) begin
      unit[0]  <= u0_next;
      unit[1]  <= u1_next;
      unit[2]  <= u2_next;
      n        <= n_next;
      end_flag <= s_tlast;
    end
  end

  `ASSERT_PROP(a_idx_in_burst, clk, rst, busy |-> (idx < n), "unit index past burst")
  `ASSERT_PROP(a_end_clears, clk, rst, (load && s_tlast) |=> (seqlen == 3'd0 && cnt == 2'd0), "sequence open after string end")
  `ASSERT_PROP(a_cnt_below_len, clk, rst, (seqlen != 3'd0) |-> (cnt != 2'd0 && {1'b0, cnt} < seqlen), "held byte count out of range")
  `ASSERT_NEVER(a_done_is_run_last, clk, rst, m_tlast && !m_tuser, "string end not on run end")

endmodule

@@ test/tb_wtf8_to_utf16_decoder.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_wtf8_to_utf16_decoder
// Feeds byte strings into the decoder with random gaps and back-pressure.
// Each accepted byte is decoded by an independent predictor, and each code
// unit that leaves the block is compared with the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_wtf8_to_utf16_decoder;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 445;

  class utf16_unit_tracker;
    typedef struct {
      w8u16dec_pkg::unit_t code_unit;
      logic                run_last;
      logic                string_done;
    } unit_rec_t;

    unit_rec_t           awaited_units[$];
    w8u16dec_pkg::unit_t fresh_units[$];
    logic [7:0]          held_bytes[3];
    int                  held_count  = 0;
    int                  open_length = 0;
    int                  mismatches  = 0;

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function int lead_class(logic [7:0] b);
      if (b[7] == 1'b0) return 1;
      if ((b & 8'hE0) == 8'hC0) return 2;
      if ((b & 8'hF0) == 8'hE0) return 3;
      if ((b & 8'hF8) == 8'hF0) return 4;
      return 0;
    endfunction

    function void decode_run(input logic [7:0] s0, s1, s2, s3, input int len);
      logic [31:0] cp;
      logic [31:0] half;
      case (len)
        2: begin
          cp = {21'd0, s0[4:0], s1[5:0]};
          fresh_units.push_back(cp[15:0]);
        end
        3: begin
          cp = {16'd0, s0[3:0], s1[5:0], s2[5:0]};
          fresh_units.push_back(cp[15:0]);
        end
        4: begin
          cp = {11'd0, s0[2:0], s1[5:0], s2[5:0], s3[5:0]} - 32'h0001_0000;
          half = 32'h0000_D800 | (cp >> 10);
          fresh_units.push_back(half[15:0]);
          half = 32'h0000_DC00 | (cp & 32'h0000_03FF);
          fresh_units.push_back(half[15:0]);
        end
        default: begin
          fresh_units.push_back({8'd0, s0});
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last_byte);
      logic [7:0] seq_bytes[8];
      unit_rec_t  rec;
      int         total;
      int         len;
      int         pos;
      foreach (seq_bytes[i]) seq_bytes[i] = 8'h00;
      fresh_units.delete();
      if (open_length < 2) begin
        len = lead_class(b);
        if (len == 1) begin
          fresh_units.push_back({8'd0, b});
        end else if (len == 0 || last_byte) begin
          fresh_units.push_back(w8u16dec_pkg::UnitReplacement);
        end else begin
          held_bytes[0] = b;
          held_count    = 1;
          open_length   = len;
        end
      end else begin
        for (int i = 0; i < held_count; i++) seq_bytes[i] = held_bytes[i];
        seq_bytes[held_count] = b;
        total = held_count + 1;
        if (total >= open_length) begin
          decode_run(seq_bytes[0], seq_bytes[1], seq_bytes[2], seq_bytes[3], open_length);
          held_count  = 0;
          open_length = 0;
        end else if (last_byte) begin
          // replace the lead, then decode what follows it as a fresh tail
          fresh_units.push_back(w8u16dec_pkg::UnitReplacement);
          pos = 1;
          while (pos < total) begin
            len = lead_class(seq_bytes[pos]);
            if (len == 0 || pos + len > total) begin
              fresh_units.push_back(w8u16dec_pkg::UnitReplacement);
              pos++;
            end else begin
              decode_run(seq_bytes[pos], seq_bytes[pos + 1], seq_bytes[pos + 2],
                         seq_bytes[pos + 3], len);
              pos += len;
            end
          end
        end else begin
          held_bytes[held_count] = b;
          held_count++;
        end
      end
      if (last_byte) begin
        held_count  = 0;
        open_length = 0;
      end
      foreach (fresh_units[k]) begin
        rec.code_unit   = fresh_units[k];
        rec.run_last    = (k == fresh_units.size() - 1);
        rec.string_done = rec.run_last && last_byte;
        awaited_units.push_back(rec);
      end
    endfunction

    task match_unit(w8u16dec_pkg::unit_t cu, logic rl, logic sd);
      unit_rec_t want;
      if (awaited_units.size() == 0) begin
        report($sformatf("unit %h arrived with nothing awaited", cu));
        return;
      end
      want = awaited_units.pop_front();
      if (cu !== want.code_unit)
        report($sformatf("code unit %h, predicted %h", cu, want.code_unit));
      if (rl !== want.run_last)
        report($sformatf("run_last %b, predicted %b on unit %h", rl, want.run_last,
                         want.code_unit));
      if (sd !== want.string_done)
        report($sformatf("string_done %b, predicted %b on unit %h", sd, want.string_done,
                         want.code_unit));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] byte_value
  logic        s_tlast  = 1'b0;   // string_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [15:0] code_unit
  logic        m_tuser;           // [0] run_last
  logic        m_tlast;           // string_done

  int                cycle_count = 0;
  logic [7:0]        text_bytes[$];
  utf16_unit_tracker tracker = new;

  logic [8:0] directed_words[] = '{
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, 8'hF8}, {1'b1, 8'h7F},
    {1'b0, 8'hC0}, {1'b0, 8'hBF},
    {1'b0, 8'hEF}, {1'b0, 8'h80}, {1'b0, 8'hBF},
    {1'b0, 8'hF0}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80},
    {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b1, 8'hBF},
    {1'b1, 8'hC2},
    {1'b0, 8'hF0}, {1'b0, 8'h41}, {1'b1, 8'h42},
    {1'b0, 8'hF4}, {1'b0, 8'hC3}, {1'b1, 8'hA9}
  };

  wtf8_to_utf16_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) tracker.match_unit(m_tdata, m_tuser, m_tlast);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void compose_text();
    int chars;
    text_bytes.delete();
    chars = $urandom_range(1, 8);
    repeat (chars) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          text_bytes.push_back(8'($urandom_range(0, 127)));
        end
        3: begin
          text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          text_bytes.push_back(follow_byte());
        end
        4, 5: begin
          text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          repeat (2) text_bytes.push_back(follow_byte());
        end
        6, 7: begin
          text_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
          repeat (3) text_bytes.push_back(follow_byte());
        end
        default: begin
          text_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // cut the string short so that its last sequence may be left open
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) if (text_bytes.size() > 1) void'(text_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last_byte, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last_byte;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : sink
    int stall_left;
    int phase_left;
    bit calm_rx;
    stall_left = 0;
    phase_left = 0;
    calm_rx    = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        calm_rx    = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!calm_rx) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int  sent;
    bit  calm;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_words[i])
      send_byte(directed_words[i][7:0], directed_words[i][8], 1'b0);
    sent = 0;
    while (sent < RandomBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      compose_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1, calm);
      sent += text_bytes.size();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_units.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_units.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ wtf8_to_utf16_decoder.f @@
+incdir+rtl
rtl/w8u16dec_pkg.sv
rtl/wtf8_to_utf16_decoder.sv
test/tb_wtf8_to_utf16_decoder.sv
